// ----- hdl/matrix2x2_modular_power_defines.svh -----
// assertion macros shared by the checker
`ifndef MATRIX2X2_MODULAR_POWER_DEFINES_SVH
`define MATRIX2X2_MODULAR_POWER_DEFINES_SVH

// same-cycle implication
`define MPOW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpow check failed");

// next-cycle implication
`define MPOW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpow check failed");

`endif

// ----- hdl/mpow_pkg.sv -----
package mpow_pkg;

    localparam int ENT_W     = 30;
    localparam int POWER_W   = 63;
    localparam int EXP_BITS_DEF = 63;
    localparam int MM_STAGES = 6;

    localparam logic [ENT_W-1:0] PRIME = 30'd1000000007;
    // floor(2^60 / prime)
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;

    typedef logic [ENT_W-1:0] ent_t;

    typedef struct packed {
        logic load;
        logic issue_mul;
        logic issue_sq;
        logic shift;
        logic finish;
    } mpow_cmd_t;

endpackage

// ----- hdl/mpow_modmul.sv -----
module mpow_modmul (
    input  logic                  clk,
    input  mpow_pkg::ent_t        a,
    input  mpow_pkg::ent_t        b,
    output mpow_pkg::ent_t        r
);
    import mpow_pkg::*;

    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] xlo2_reg;
    logic [31:0] qp_reg;
    logic [31:0] xlo3_reg;
    logic [31:0] r_reg;
    logic [30:0] r1_reg;
    logic [29:0] r2_reg;

    logic [61:0] q2_next;
    logic [60:0] qp_full;
    logic [31:0] r_next;
    logic [30:0] r1_next;
    logic [29:0] r2_next;

    always_comb
    begin
        q2_next = 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
        qp_full = 61'(q2_reg[61:31]) * 61'(PRIME);
        r_next  = xlo3_reg - qp_reg;
        // barrett leaves the remainder below three times the prime
        r1_next = (r_reg >= 32'(PRIME)) ? 31'(r_reg - 32'(PRIME)) : r_reg[30:0];
        r2_next = (r1_reg >= 31'(PRIME)) ? 30'(r1_reg - 31'(PRIME)) : r1_reg[29:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 60'(a) * 60'(b);
        q2_reg   <= q2_next;
        xlo2_reg <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        xlo3_reg <= xlo2_reg;
        r_reg    <= r_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
    end

    assign r = r2_reg;

endmodule

// ----- hdl/mpow_datapath.sv -----
module mpow_datapath #(
    parameter int EXP_BITS = mpow_pkg::EXP_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mpow_pkg::mpow_cmd_t          cmd,
    input  mpow_pkg::ent_t               m00,
    input  mpow_pkg::ent_t               m01,
    input  mpow_pkg::ent_t               m10,
    input  mpow_pkg::ent_t               m11,
    input  logic [mpow_pkg::POWER_W-1:0] power,
    output mpow_pkg::ent_t               r00,
    output mpow_pkg::ent_t               r01,
    output mpow_pkg::ent_t               r10,
    output mpow_pkg::ent_t               r11
);
    import mpow_pkg::*;

    ent_t base_reg [2][2];
    ent_t acc_reg  [2][2];
    ent_t out_reg  [2][2];
    ent_t zsum     [2][2];
    logic [EXP_BITS-1:0] exp_reg;

    // write tags travel alongside the multiplier pipeline
    logic [MM_STAGES-1:0] vld_reg, vld_next;
    logic [MM_STAGES-1:0] kind_reg;

    ent_t opa [8];
    ent_t opb [8];
    ent_t prd [8];

    genvar gi, gj, gk;
    generate
        for (gi = 0; gi < 2; gi++) begin : g_row
            for (gj = 0; gj < 2; gj++) begin : g_col
                for (gk = 0; gk < 2; gk++) begin : g_term
                    assign opa[gi*4+gj*2+gk] = cmd.issue_sq ? base_reg[gi][gk]
                                                            : acc_reg[gi][gk];
                    assign opb[gi*4+gj*2+gk] = base_reg[gk][gj];
                    mpow_modmul u_mm (
                        .clk (clk),
                        .a   (opa[gi*4+gj*2+gk]),
                        .b   (opb[gi*4+gj*2+gk]),
                        .r   (prd[gi*4+gj*2+gk])
                    );
                end
                always_comb
                begin
                    logic [ENT_W:0] s;
                    s = {1'b0, prd[gi*4+gj*2]} + {1'b0, prd[gi*4+gj*2+1]};
                    zsum[gi][gj] = (s >= 31'(PRIME)) ? ENT_W'(s - 31'(PRIME))
                                                     : s[ENT_W-1:0];
                end
            end
        end
    endgenerate

    always_comb
    begin
        vld_next = {vld_reg[MM_STAGES-2:0], (cmd.issue_mul & exp_reg[0]) | cmd.issue_sq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= {kind_reg[MM_STAGES-2:0], cmd.issue_sq};
        if (cmd.load)
        begin
            base_reg[0][0] <= m00;
            base_reg[0][1] <= m01;
            base_reg[1][0] <= m10;
            base_reg[1][1] <= m11;
            acc_reg[0][0]  <= ENT_W'(1);
            acc_reg[0][1]  <= '0;
            acc_reg[1][0]  <= '0;
            acc_reg[1][1]  <= ENT_W'(1);
            exp_reg        <= power[EXP_BITS-1:0];
        end
        else
        begin
            if (vld_reg[MM_STAGES-1])
            begin
                if (kind_reg[MM_STAGES-1])
                begin
                    base_reg <= zsum;
                end
                else
                begin
                    acc_reg <= zsum;
                end
            end
            if (cmd.shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.finish)
        begin
            out_reg <= acc_reg;
        end
    end

    assign r00 = out_reg[0][0];
    assign r01 = out_reg[0][1];
    assign r10 = out_reg[1][0];
    assign r11 = out_reg[1][1];

endmodule

// ----- hdl/mpow_ctrl.sv -----
module mpow_ctrl #(
    parameter int EXP_BITS = mpow_pkg::EXP_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output mpow_pkg::mpow_cmd_t cmd
);
    import mpow_pkg::*;

    localparam int CNT_W  = $clog2(EXP_BITS + 1);
    localparam int WAIT_W = $clog2(MM_STAGES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  bit_reg, bit_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              done_reg, done_next;
    logic              last_wait;

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        wait_next  = wait_reg;
        cmd        = '0;
        last_wait  = (wait_reg == WAIT_W'(MM_STAGES - 1));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    bit_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.issue_mul = 1'b1;
                state_next    = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.issue_sq = 1'b1;
                wait_next    = '0;
                state_next   = ST_WAIT;
            end
            ST_WAIT:
            begin
                wait_next = wait_reg + WAIT_W'(1);
                if (last_wait)
                begin
                    cmd.shift = 1'b1;
                    bit_next  = bit_reg + CNT_W'(1);
                    state_next = (bit_reg == CNT_W'(EXP_BITS - 1)) ? ST_FIN : ST_MUL;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = (state_reg == ST_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            wait_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ----- hdl/matrix2x2_modular_power.sv -----
// 2x2 matrix power modulo 1000000007, square-and-multiply from the low bit up
//
// request channel: m00..m11 and power are taken at a rising edge where start
// is high and busy is low; busy then stays high until the request is done
// result channel: done pulses for exactly one cycle with r00..r11 valid;
// the receiver cannot stall, so a done pulse not seen in that cycle is gone
// r00..r11 keep their value until the next result is written
// each exponent bit takes a multiply issue, a square issue, then the
// 6-stage barrett pipeline draining; done is registered from the finish
// state after the last bit; one request is handled at a time, busy high
// until it is done; busy drops while done is shown, so the next request
// may be accepted in the done cycle; the length of a request is set by
// the one 6-stage modular multiplier pipeline per term (eight lanes) and
// by each bit waiting on the squared base of the previous bit
// exponent bits above EXP_BITS are ignored; power 0 gives the identity
// reset (rst_n low, asynchronous) returns the controller to idle and drops
// done; no state is kept between requests
module matrix2x2_modular_power #(
    parameter int EXP_BITS = mpow_pkg::EXP_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mpow_pkg::ent_t               m00,
    input  mpow_pkg::ent_t               m01,
    input  mpow_pkg::ent_t               m10,
    input  mpow_pkg::ent_t               m11,
    input  logic [mpow_pkg::POWER_W-1:0] power,
    output logic                         done,
    output mpow_pkg::ent_t               r00,
    output mpow_pkg::ent_t               r01,
    output mpow_pkg::ent_t               r10,
    output mpow_pkg::ent_t               r11
);
    import mpow_pkg::*;

    // command bundle from the sequencer to the datapath
    mpow_cmd_t cmd;

    // sequencer: one multiply and one square per exponent bit
    mpow_ctrl #(
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // datapath: base, accumulator, exponent shifter and eight mod-mul lanes
    mpow_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .m00   (m00),
        .m01   (m01),
        .m10   (m10),
        .m11   (m11),
        .power (power),
        .r00   (r00),
        .r01   (r01),
        .r10   (r10),
        .r11   (r11)
    );

endmodule

// ----- hdl/mpow_checker.sv -----
`include "matrix2x2_modular_power_defines.svh"

module mpow_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input mpow_pkg::ent_t r00,
    input mpow_pkg::ent_t r01,
    input mpow_pkg::ent_t r10,
    input mpow_pkg::ent_t r11
);
    import mpow_pkg::*;

    `MPOW_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `MPOW_ASSERT_NOW(a_done_idle, done, !busy)
    `MPOW_ASSERT_NEXT(a_done_pulse, done, !done)
    `MPOW_ASSERT_NOW(a_reduced, done, (r00 < PRIME) && (r01 < PRIME) && (r10 < PRIME) && (r11 < PRIME))

endmodule

bind matrix2x2_modular_power mpow_checker u_mpow_checker (.*);

// ----- sim/matrix2x2_modular_power_tb.sv -----
module matrix2x2_modular_power_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpow_pkg::*;

    localparam int NUM_RANDOM = 1875;
    localparam longint unsigned P64 = 64'd1000000007;

    // a 2x2 matrix as four entries, row major
    typedef struct {
        longint unsigned e00, e01, e10, e11;
    } mat_t;

    // one row of directed stimulus; known_res marks rows whose answer is typed in
    typedef struct {
        ent_t             a00, a01, a10, a11;
        logic [POWER_W-1:0] pw;
        bit               known_res;
        ent_t             x00, x01, x10, x11;
    } stim_row_t;

    typedef struct {
        ent_t r00, r01, r10, r11;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    ent_t               m00, m01, m10, m11;
    logic [POWER_W-1:0] power;
    logic               done;
    ent_t               r00, r01, r10, r11;

    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    int        fail_count;

    matrix2x2_modular_power dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .m00   (m00),
        .m01   (m01),
        .m10   (m10),
        .m11   (m11),
        .power (power),
        .done  (done),
        .r00   (r00),
        .r01   (r01),
        .r10   (r10),
        .r11   (r11)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sum of two reduced entry products, reduced again
    function automatic longint unsigned mod_pair_sum(longint unsigned a, longint unsigned b,
                                                     longint unsigned c, longint unsigned d);
        longint unsigned s;
        s = (a * b) % P64 + (c * d) % P64;
        return s % P64;
    endfunction

    function automatic mat_t mat_product(mat_t x, mat_t y);
        mat_t z;
        z.e00 = mod_pair_sum(x.e00, y.e00, x.e01, y.e10);
        z.e01 = mod_pair_sum(x.e00, y.e01, x.e01, y.e11);
        z.e10 = mod_pair_sum(x.e10, y.e00, x.e11, y.e10);
        z.e11 = mod_pair_sum(x.e10, y.e01, x.e11, y.e11);
        return z;
    endfunction

    // square-and-multiply from the lowest exponent bit up
    function automatic result_t matrix_power_mod(ent_t a00, ent_t a01, ent_t a10, ent_t a11,
                                                 logic [POWER_W-1:0] pw);
        mat_t    base;
        mat_t    acc;
        result_t res;
        // unreduced entries are folded into range first
        base.e00 = longint'(a00) % P64;
        base.e01 = longint'(a01) % P64;
        base.e10 = longint'(a10) % P64;
        base.e11 = longint'(a11) % P64;
        acc.e00 = 1;
        acc.e01 = 0;
        acc.e10 = 0;
        acc.e11 = 1;
        for (int i = 0; i < POWER_W; i++)
        begin
            if (pw[i])
                acc = mat_product(acc, base);
            base = mat_product(base, base);
        end
        res.r00 = ent_t'(acc.e00);
        res.r01 = ent_t'(acc.e01);
        res.r10 = ent_t'(acc.e10);
        res.r11 = ent_t'(acc.e11);
        return res;
    endfunction

    // entries: extremes, unreduced values, and values in range
    function automatic ent_t random_entry();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PRIME - 1;
            2: return ent_t'($urandom);
            3: return '1;
            4: return ent_t'($urandom_range(0, 3));
            default: return ent_t'($urandom % 32'd1000000007);
        endcase
    endfunction

    // exponents: short, full width, single bits and runs of ones
    function automatic logic [POWER_W-1:0] random_power();
        logic [POWER_W-1:0] full;
        full = POWER_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: return POWER_W'($urandom_range(0, 20));
            1: return POWER_W'(1) << $urandom_range(0, POWER_W - 1);
            2: return (POWER_W'(1) << $urandom_range(1, POWER_W - 1)) - 1;
            3: return '1;
            default: return full;
        endcase
    endfunction

    // present one request after an optional idle gap, hold it until busy is low at an edge
    task automatic send_request(ent_t a00, ent_t a01, ent_t a10, ent_t a11,
                                logic [POWER_W-1:0] pw, int gap, result_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        m00   <= a00;
        m01   <= a01;
        m10   <= a10;
        m11   <= a11;
        power <= pw;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(want);
    endtask

    // result checker: done is a one-cycle strobe, no back-pressure
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding: %0d %0d %0d %0d",
                         $time, r00, r01, r10, r11);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (r00 !== want.r00)
                begin
                    $display("%0t: r00 expected %0d actual %0d", $time, want.r00, r00);
                    fail_count++;
                end
                if (r01 !== want.r01)
                begin
                    $display("%0t: r01 expected %0d actual %0d", $time, want.r01, r01);
                    fail_count++;
                end
                if (r10 !== want.r10)
                begin
                    $display("%0t: r10 expected %0d actual %0d", $time, want.r10, r10);
                    fail_count++;
                end
                if (r11 !== want.r11)
                begin
                    $display("%0t: r11 expected %0d actual %0d", $time, want.r11, r11);
                    fail_count++;
                end
            end
        end
    end

    // watchdog, well beyond 1900 requests, each with the longest gap
    initial
    begin
        #50ms;
        $display("matrix2x2_modular_power test failed");
        $finish;
    end

    initial
    begin
        ent_t      all_ones;
        ent_t      pm1;
        ent_t      folded;
        result_t   want;
        stim_row_t row;
        int        gap;
        bit        burst;

        all_ones = '1;
        pm1      = PRIME - 1;
        // 2^30-1 folded once by the prime
        folded   = all_ones - PRIME;

        fail_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        m00   = '0;
        m01   = '0;
        m10   = '0;
        m11   = '0;
        power = '0;

        // zero exponent gives the identity whatever the base
        directed_rows.push_back('{'0, '0, '0, '0, '0, 1'b1, 1, 0, 0, 1});
        directed_rows.push_back('{all_ones, all_ones, all_ones, all_ones, '0, 1'b1, 1, 0, 0, 1});
        directed_rows.push_back('{pm1, pm1, pm1, pm1, '0, 1'b1, 1, 0, 0, 1});
        // exponent one returns the base, reduced
        directed_rows.push_back('{pm1, 0, 1, pm1, 1, 1'b1, pm1, 0, 1, pm1});
        directed_rows.push_back('{all_ones, PRIME, 5, all_ones, 1, 1'b1, folded, 0, 5, folded});
        // zero matrix and identity at the largest exponent, zero matrix at exponent one
        directed_rows.push_back('{'0, '0, '0, '0, '1, 1'b1, 0, 0, 0, 0});
        directed_rows.push_back('{1, 0, 0, 1, '1, 1'b1, 1, 0, 0, 1});
        directed_rows.push_back('{0, 0, 0, 0, 1, 1'b1, 0, 0, 0, 0});
        // predictor rows: fibonacci, top exponent bit, extremes, unreduced
        directed_rows.push_back('{1, 1, 1, 0, 10, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{1, 1, 1, 0, 63'h4000000000000000, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{pm1, pm1, pm1, pm1, '1, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{all_ones, all_ones, all_ones, all_ones, '1, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{all_ones, 0, 0, all_ones, 2, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{2, 3, 5, 7, 63'h5555555555555555, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{pm1, 1, 0, pm1, 63'h2AAAAAAAAAAAAAAA, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{PRIME, PRIME, all_ones, 3, 3, 1'b0, 0, 0, 0, 0});
        directed_rows.push_back('{123456789, 987654321, 55555, 1000000000, 1000000006,
                                  1'b0, 0, 0, 0, 0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.known_res)
                want = '{row.x00, row.x01, row.x10, row.x11};
            else
                want = matrix_power_mod(row.a00, row.a01, row.a10, row.a11, row.pw);
            send_request(row.a00, row.a01, row.a10, row.a11, row.pw,
                         (i % 3 == 0) ? 0 : $urandom_range(0, 13), want);
        end

        // random part, stretches of back-to-back or gapped requests, picked at random every 50 requests
        burst = 1'b0;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            ent_t               a00, a01, a10, a11;
            logic [POWER_W-1:0] pw;
            if (n % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            a00 = random_entry();
            a01 = random_entry();
            a10 = random_entry();
            a11 = random_entry();
            pw  = random_power();
            gap = burst ? 0 : $urandom_range(0, 13);
            send_request(a00, a01, a10, a11, pw, gap,
                         matrix_power_mod(a00, a01, a10, a11, pw));
        end
        start <= 1'b0;

        // drain: wait until every outstanding result has been checked
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (fail_count == 0)
            $display("matrix2x2_modular_power test passed");
        else
            $display("matrix2x2_modular_power test failed");
        $finish;
    end

endmodule
